FILE: design/usb_audio_control_request_handler_top_assert.svh
// Assertion macros used by the checker file uac_checker.sv.
`ifndef USB_AUDIO_CONTROL_REQUEST_HANDLER_TOP_ASSERT_SVH
`define USB_AUDIO_CONTROL_REQUEST_HANDLER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define UAC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("uac assertion failed");

// Next-cycle implication, off during reset.
`define UAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("uac assertion failed");

`endif

FILE: design/uac_pkg.sv
package uac_pkg;

  localparam int unsigned InTdataW  = 96;
  localparam int unsigned OutTdataW = 40;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StStall = 2'd1,
    StAwait = 2'd2,
    StDesc  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegFloor   = 2'd0,
    RegCeiling = 2'd1,
    RegStep    = 2'd2,
    RegUnitId  = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] ReqSetCur  = 8'h01;
  localparam logic [7:0] ReqGetCur  = 8'h81;
  localparam logic [7:0] ReqGetMin  = 8'h82;
  localparam logic [7:0] ReqGetMax  = 8'h83;
  localparam logic [7:0] ReqGetRes  = 8'h84;
  localparam logic [7:0] ReqGetDesc = 8'd6;
  localparam logic [7:0] ReqGetConf = 8'd8;
  localparam logic [7:0] ReqSetConf = 8'd9;
  localparam logic [7:0] ReqGetIntf = 8'd10;
  localparam logic [7:0] ReqSetIntf = 8'd11;

  localparam logic [1:0] CatStandard = 2'd0;
  localparam logic [1:0] CatClass    = 2'd1;

  localparam logic [7:0] SelMute   = 8'd1;
  localparam logic [7:0] SelVolume = 8'd2;

  localparam logic [7:0] DescDevice = 8'd1;
  localparam logic [7:0] DescConfig = 8'd2;
  localparam logic [7:0] DescString = 8'd3;
  localparam logic [7:0] MaxStringIdx = 8'd6;

  localparam logic signed [15:0] FloorReset  = -16'sd16128;
  localparam logic signed [15:0] CeilReset   = 16'sd0;
  localparam logic [14:0]        StepReset   = 15'd256;
  localparam logic [7:0]         UnitReset   = 8'd2;
  localparam logic signed [15:0] VolumeReset = -16'sd2560;

endpackage

FILE: design/usb_audio_control_request_handler_top.sv
// USB audio feature-unit control request handler.
// Slave stream s_axis_*: one control setup request per item, or a bus
// disconnect event when tuser is high. Master stream m_axis_*: exactly one
// result per item, giving status, reply length, reply bytes and the state
// after the request (configured, streaming, mute, volume).
// Config channel cfg_*: writes volume floor, ceiling, step and unit id;
// always ready, and only to be written while no item is in flight.
// A result appears on m_axis in the cycle after its item is taken.
// Throughput: one item per cycle unless m_axis stalls; decode, clamp and
// state update form one stage between slave handshake and result register.
// s_axis_tready is high while the result register is empty or being taken,
// so a stalled receiver holds the result and blocks further items.
// Reset: result register empties, state returns to unconfigured, not
// streaming, unmuted, volume -10 dB; config registers take their defaults.
module usb_audio_control_request_handler_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // request_type, request_code, value_word, index_word, length_word,
  // data_present, data_count, data_first, data_second, zero fill
  input  logic [uac_pkg::InTdataW-1:0]     s_axis_tdata,
  // kind
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, reply_length, reply_low, reply_high, configured,
  // streaming_on, muted, volume_now, zero fill
  output logic [uac_pkg::OutTdataW-1:0]    m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [uac_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [uac_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic signed [15:0] floor_q, ceil_q;
  logic [14:0]        step_q;
  logic [7:0]         unit_q;

  logic               config_q, config_d;
  logic               stream_q, stream_d;
  logic               mute_q, mute_d;
  logic signed [15:0] volume_q, volume_d;

  logic                          out_valid_q;
  logic [uac_pkg::OutTdataW-1:0] out_data_q, out_data_d;

  logic        in_acc;
  logic [7:0]  rtype, code, d0, d1, count, sel, iface;
  logic [15:0] wval, widx, wlen;
  logic        present;
  logic [1:0]  cat;
  logic signed [15:0] vset;
  logic [15:0] vget;

  uac_pkg::status_e status;
  logic [1:0]  rlen;
  logic [7:0]  b0, b1;

  function automatic logic [1:0] short_len(logic [1:0] natural, logic [15:0] wl);
    logic [1:0] r;
    if (wl < {14'd0, natural}) r = wl[1:0];
    else r = natural;
    return r;
  endfunction

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign rtype   = s_axis_tdata[7:0];
  assign code    = s_axis_tdata[15:8];
  assign wval    = s_axis_tdata[31:16];
  assign widx    = s_axis_tdata[47:32];
  assign wlen    = s_axis_tdata[63:48];
  assign present = s_axis_tdata[64];
  assign count   = s_axis_tdata[72:65];
  assign d0      = s_axis_tdata[80:73];
  assign d1      = s_axis_tdata[88:81];
  assign sel     = wval[15:8];
  assign iface   = widx[7:0];
  assign cat     = rtype[6:5];
  assign vset    = signed'({d1, d0});

  always_comb begin
    unique case (code)
      uac_pkg::ReqGetMin: vget = floor_q;
      uac_pkg::ReqGetMax: vget = ceil_q;
      uac_pkg::ReqGetRes: vget = {1'b0, step_q};
      default:            vget = volume_q;
    endcase
  end

  always_comb begin
    status   = uac_pkg::StStall;
    rlen     = 2'd0;
    b0       = 8'd0;
    b1       = 8'd0;
    config_d = config_q;
    stream_d = stream_q;
    mute_d   = mute_q;
    volume_d = volume_q;
    if (s_axis_tuser) begin
      config_d = 1'b0;
      stream_d = 1'b0;
      status   = uac_pkg::StOk;
    end else if (cat == uac_pkg::CatClass) begin
      if (widx[15:8] != unit_q) begin
        status = uac_pkg::StStall;
      end else if (code == uac_pkg::ReqSetCur) begin
        if (!present) begin
          status = (wlen != 16'd0) ? uac_pkg::StAwait : uac_pkg::StOk;
        end else if (sel == uac_pkg::SelMute && count >= 8'd1) begin
          mute_d = (d0 != 8'd0);
          status = uac_pkg::StOk;
        end else if (sel == uac_pkg::SelVolume && count >= 8'd2) begin
          if (vset < floor_q) volume_d = floor_q;
          else if (vset > ceil_q) volume_d = ceil_q;
          else volume_d = vset;
          status = uac_pkg::StOk;
        end
      end else if (sel == uac_pkg::SelMute && code == uac_pkg::ReqGetCur) begin
        b0     = {7'd0, mute_q};
        rlen   = short_len(2'd1, wlen);
        status = uac_pkg::StOk;
      end else if (sel == uac_pkg::SelVolume && code >= uac_pkg::ReqGetCur &&
                   code <= uac_pkg::ReqGetRes) begin
        b0     = vget[7:0];
        b1     = vget[15:8];
        rlen   = short_len(2'd2, wlen);
        status = uac_pkg::StOk;
      end
    end else if (cat == uac_pkg::CatStandard) begin
      unique case (code)
        uac_pkg::ReqGetDesc: begin
          if (sel == uac_pkg::DescDevice || sel == uac_pkg::DescConfig ||
              (sel == uac_pkg::DescString && wval[7:0] <= uac_pkg::MaxStringIdx)) begin
            status = uac_pkg::StDesc;
          end
        end
        uac_pkg::ReqSetConf: begin
          if (wval == 16'd0) begin
            stream_d = 1'b0;
            config_d = 1'b0;
            status   = uac_pkg::StOk;
          end else if (wval == 16'd1) begin
            config_d = 1'b1;
            status   = uac_pkg::StOk;
          end
        end
        uac_pkg::ReqGetConf: begin
          b0     = {7'd0, config_q};
          rlen   = short_len(2'd1, wlen);
          status = uac_pkg::StOk;
        end
        uac_pkg::ReqSetIntf: begin
          if (iface == 8'd1 && wval <= 16'd1) begin
            if (wval == 16'd1) begin
              if (config_q) begin
                stream_d = 1'b1;
                status   = uac_pkg::StOk;
              end
            end else begin
              stream_d = 1'b0;
              status   = uac_pkg::StOk;
            end
          end else if (iface == 8'd0 && wval == 16'd0) begin
            status = uac_pkg::StOk;
          end
        end
        uac_pkg::ReqGetIntf: begin
          if (iface == 8'd1 || iface == 8'd0) begin
            b0     = {7'd0, (iface == 8'd1) && stream_q};
            rlen   = short_len(2'd1, wlen);
            status = uac_pkg::StOk;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_data_d = {1'b0, volume_d, mute_d, stream_d, config_d, b1, b0, rlen, status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= uac_pkg::FloorReset;
      ceil_q  <= uac_pkg::CeilReset;
      step_q  <= uac_pkg::StepReset;
      unit_q  <= uac_pkg::UnitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (uac_pkg::cfg_reg_e'(cfg_index_i))
        uac_pkg::RegFloor:   floor_q <= signed'(cfg_data_i);
        uac_pkg::RegCeiling: ceil_q  <= signed'(cfg_data_i);
        uac_pkg::RegStep:    step_q  <= cfg_data_i[14:0];
        uac_pkg::RegUnitId:  unit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      config_q    <= 1'b0;
      stream_q    <= 1'b0;
      mute_q      <= 1'b0;
      volume_q    <= uac_pkg::VolumeReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        config_q <= config_d;
        stream_q <= stream_d;
        mute_q   <= mute_d;
        volume_q <= volume_d;
      end
      if (in_acc) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: design/uac_checker.sv
`include "usb_audio_control_request_handler_top_assert.svh"

module uac_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [uac_pkg::InTdataW-1:0]     s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [uac_pkg::OutTdataW-1:0]    m_axis_tdata,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [uac_pkg::CfgIdxW-1:0]      cfg_index_i,
  input logic [uac_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic unused;
  assign unused = s_axis_tvalid ^ (^s_axis_tdata) ^ s_axis_tuser ^ cfg_valid_i ^
                  cfg_ready_o ^ (^cfg_index_i) ^ (^cfg_data_i);

  `UAC_ASSERT_NOW(a_stream_needs_config, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[21], m_axis_tdata[20])

  `UAC_ASSERT_NOW(a_stall_no_reply, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[1:0] != uac_pkg::StOk, m_axis_tdata[3:2] == 2'd0)

  `UAC_ASSERT_NOW(a_not_ok_zero_bytes, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[1:0] != uac_pkg::StOk, m_axis_tdata[19:4] == 16'd0)

  `UAC_ASSERT_NEXT(a_result_holds, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  `UAC_ASSERT_NEXT(a_stall_blocks_input, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind usb_audio_control_request_handler_top uac_checker u_uac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i)
);
